// ===== rtl/bfns_pkg.sv =====
`timescale 1ns / 1ps
package bfns_pkg;

    localparam int OFFSET_W     = 16;
    localparam int WCOUNT_W     = 11;
    localparam int WCOUNT_RESET = 1024;

    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_TEST   = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

endpackage

// ===== rtl/bfns_if.sv =====
`timescale 1ns / 1ps
interface bfns_in_if;
    import bfns_pkg::*;

    logic                valid;
    logic                ready;
    t_cmd                command;
    logic [OFFSET_W-1:0] bit_offset;
    logic                bit_value;

    modport source (output valid, command, bit_offset, bit_value, input ready);
    modport sink   (input valid, command, bit_offset, bit_value, output ready);
endinterface

interface bfns_out_if;
    import bfns_pkg::*;

    logic                valid;
    logic                ready;
    logic                bit_is_set;
    logic                found;
    logic [OFFSET_W-1:0] found_index;
    logic                range_error;

    modport source (output valid, bit_is_set, found, found_index, range_error,
                    input ready);
    modport sink   (input valid, bit_is_set, found, found_index, range_error,
                    output ready);
endinterface

// ===== rtl/bitmap_find_next_set_unit.sv =====
`timescale 1ns / 1ps
// write and test: S_DIV, S_ISSUE, S_RMW, then S_RESP registers the result; one item at a time
// search: S_SCAN goes word by word to a hit (then S_FIDX) or the last word; one read per word
// range error: S_ISSUE to S_RESP; clear all: S_CLEAR, one memory word zeroed per cycle
// next input taken the cycle after a result is registered; a waiting result stalls in S_RESP
// reset (i_rst_n low, synchronous): word_count back to 1024, then a clearing pass in
// S_CLEAR zeroes the bitmap memory, input ready stays low meanwhile
module bitmap_find_next_set_unit #(
    parameter int WORD_BITS = 64,
    parameter int WORDS     = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bfns_pkg::WCOUNT_W-1:0] i_cfg_wdata,
    bfns_in_if.sink                       i_in,
    bfns_out_if.source                    o_out
);
    import bfns_pkg::*;

    localparam int AW  = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BW  = $clog2(WORD_BITS);
    localparam int PW  = OFFSET_W + 7;
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / WORD_BITS);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_DIV   = 8'b0000_0010,
        S_ISSUE = 8'b0000_0100,
        S_RMW   = 8'b0000_1000,
        S_SCAN  = 8'b0001_0000,
        S_FIDX  = 8'b0010_0000,
        S_CLEAR = 8'b0100_0000,
        S_RESP  = 8'b1000_0000
    } t_state;

    logic [WORD_BITS-1:0] r_mem [WORDS];
    logic [WORD_BITS-1:0] r_rd;

    t_state               r_state, n_state;
    logic [WCOUNT_W-1:0]  r_word_count;
    t_cmd                 r_cmd, n_cmd;
    logic [OFFSET_W-1:0]  r_off, n_off;
    logic                 r_val, n_val;
    logic [OFFSET_W-1:0]  r_qest, n_qest;
    logic [OFFSET_W-1:0]  r_widx, n_widx;
    logic [BW-1:0]        r_bpos, n_bpos;
    logic [AW-1:0]        r_chk_w, n_chk_w;
    logic [BW-1:0]        r_pos, n_pos;
    logic [AW-1:0]        r_clr_addr, n_clr_addr;
    logic                 r_clr_resp, n_clr_resp;
    logic                 r_res_bit, n_res_bit;
    logic                 r_res_found, n_res_found;
    logic [OFFSET_W-1:0]  r_res_idx, n_res_idx;
    logic                 r_res_err, n_res_err;
    logic                 r_out_valid, n_out_valid;
    logic                 r_out_bit, n_out_bit;
    logic                 r_out_found, n_out_found;
    logic [OFFSET_W-1:0]  r_out_idx, n_out_idx;
    logic                 r_out_err, n_out_err;

    logic                 mem_we, mem_re;
    logic [AW-1:0]        mem_waddr, mem_raddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [WCOUNT_W-1:0]  wc_eff;
    logic [48:0]          qprod;
    logic [PW-1:0]        qback, rem;
    logic [WORD_BITS-1:0] scan_v;
    logic [BW-1:0]        scan_pos;
    logic                 in_acc;

    assign in_acc        = i_in.valid && i_in.ready;
    assign i_in.ready    = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.bit_is_set  = r_out_bit;
    assign o_out.found       = r_out_found;
    assign o_out.found_index = r_out_idx;
    assign o_out.range_error = r_out_err;

    // zero count acts as one word, counts above the memory depth saturate
    always_comb begin
        if (r_word_count == '0) begin
            wc_eff = WCOUNT_W'(1);
        end else if (r_word_count > WCOUNT_W'(WORDS)) begin
            wc_eff = WCOUNT_W'(WORDS);
        end else begin
            wc_eff = r_word_count;
        end
    end

    // quotient estimate is low by at most one, fixed up in S_DIV
    assign qprod = 49'(i_in.bit_offset) * 49'(RECIP);
    assign qback = PW'(r_qest) * PW'(WORD_BITS);
    assign rem   = PW'(r_off) - qback;

    always_comb begin
        if (r_chk_w == r_widx[AW-1:0]) begin
            scan_v = r_rd & ({WORD_BITS{1'b1}} << r_bpos);
        end else begin
            scan_v = r_rd;
        end
        scan_pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (scan_v[i]) begin
                scan_pos = BW'(i);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_off       = r_off;
        n_val       = r_val;
        n_qest      = r_qest;
        n_widx      = r_widx;
        n_bpos      = r_bpos;
        n_chk_w     = r_chk_w;
        n_pos       = r_pos;
        n_clr_addr  = r_clr_addr;
        n_clr_resp  = r_clr_resp;
        n_res_bit   = r_res_bit;
        n_res_found = r_res_found;
        n_res_idx   = r_res_idx;
        n_res_err   = r_res_err;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_bit   = r_out_bit;
        n_out_found = r_out_found;
        n_out_idx   = r_out_idx;
        n_out_err   = r_out_err;
        mem_we      = 1'b0;
        mem_waddr   = r_widx[AW-1:0];
        mem_wdata   = r_rd;
        mem_re      = 1'b0;
        mem_raddr   = r_widx[AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_cmd       = i_in.command;
                    n_off       = i_in.bit_offset;
                    n_val       = i_in.bit_value;
                    n_qest      = qprod[32 +: OFFSET_W];
                    n_res_bit   = 1'b0;
                    n_res_found = 1'b0;
                    n_res_idx   = '0;
                    n_res_err   = 1'b0;
                    if (i_in.command == CMD_CLEAR) begin
                        n_state    = S_CLEAR;
                        n_clr_addr = '0;
                        n_clr_resp = 1'b1;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (rem >= PW'(WORD_BITS)) begin
                    n_widx = r_qest + OFFSET_W'(1);
                    n_bpos = BW'(rem - PW'(WORD_BITS));
                end else begin
                    n_widx = r_qest;
                    n_bpos = BW'(rem);
                end
                n_state = S_ISSUE;
            end
            S_ISSUE: begin
                if (r_widx >= OFFSET_W'(wc_eff)) begin
                    n_res_err = 1'b1;
                    n_state   = S_RESP;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_widx[AW-1:0];
                    n_chk_w   = r_widx[AW-1:0];
                    n_state   = (r_cmd == CMD_SEARCH) ? S_SCAN : S_RMW;
                end
            end
            S_RMW: begin
                if (r_cmd == CMD_WRITE) begin
                    mem_we            = 1'b1;
                    mem_wdata[r_bpos] = r_val;
                end else begin
                    n_res_bit = r_rd[r_bpos];
                end
                n_state = S_RESP;
            end
            S_SCAN: begin
                // r_rd holds word r_chk_w; fetch the next one while checking this one
                if (scan_v != '0) begin
                    n_res_found = 1'b1;
                    n_pos       = scan_pos;
                    n_state     = S_FIDX;
                end else if (WCOUNT_W'(r_chk_w) + WCOUNT_W'(1) >= wc_eff) begin
                    n_state = S_RESP;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_chk_w + AW'(1);
                    n_chk_w   = r_chk_w + AW'(1);
                end
            end
            S_FIDX: begin
                n_res_idx = OFFSET_W'(OFFSET_W'(r_chk_w) * OFFSET_W'(WORD_BITS))
                          + OFFSET_W'(r_pos);
                n_state   = S_RESP;
            end
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = '0;
                if (r_clr_addr == AW'(WORDS - 1)) begin
                    n_clr_addr = '0;
                    n_state    = r_clr_resp ? S_RESP : S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + AW'(1);
                end
            end
            S_RESP: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_bit   = r_res_bit;
                    n_out_found = r_res_found;
                    n_out_idx   = r_res_idx;
                    n_out_err   = r_res_err;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_clr_resp   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_word_count <= WCOUNT_W'(WCOUNT_RESET);
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_clr_resp  <= n_clr_resp;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_word_count <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_off       <= n_off;
        r_val       <= n_val;
        r_qest      <= n_qest;
        r_widx      <= n_widx;
        r_bpos      <= n_bpos;
        r_chk_w     <= n_chk_w;
        r_pos       <= n_pos;
        r_res_bit   <= n_res_bit;
        r_res_found <= n_res_found;
        r_res_idx   <= n_res_idx;
        r_res_err   <= n_res_err;
        r_out_bit   <= n_out_bit;
        r_out_found <= n_out_found;
        r_out_idx   <= n_out_idx;
        r_out_err   <= n_out_err;
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
module tb;
    import bfns_pkg::*;

    localparam int          WORD_BITS   = 64;
    localparam int          WORDS       = 1024;
    localparam int          CLK_HALF    = 6;
    localparam int          RESET_LEN   = 7;
    localparam int          CYCLE_LIMIT = 8_000_000;
    localparam int          PHASES      = 9;
    localparam int          PHASE_ITEMS = 160;
    localparam int unsigned HOLD_AT     = 1000;
    localparam int unsigned HOLD_LEN    = 400;
    localparam int          MAX_REPORTS = 10;

    typedef struct {
        logic                bit_is_set;
        logic                found;
        logic [OFFSET_W-1:0] found_index;
        logic                range_error;
    } t_answer;

    // keeps a copy of the mark bitmap and the answers still owed by the block
    class bitmap_tracker;
        logic [WORD_BITS-1:0] marks [WORDS];
        int unsigned          word_count;
        t_answer              pending_answers[$];
        int unsigned          mismatches;

        function new();
            clear_marks();
            word_count = WCOUNT_RESET;
            mismatches = 0;
        endfunction

        function void clear_marks();
            foreach (marks[i]) marks[i] = '0;
        endfunction

        function void set_word_count(logic [WCOUNT_W-1:0] value);
            word_count = value;
        endfunction

        function int unsigned words_in_use();
            if (word_count == 0) return 1;
            if (word_count > WORDS) return WORDS;
            return word_count;
        endfunction

        function void note_command(t_cmd cmd, logic [OFFSET_W-1:0] offset, logic value);
            t_answer              ans;
            int unsigned          wc;
            int unsigned          widx;
            int unsigned          bpos;
            int unsigned          w;
            int unsigned          b;
            logic [WORD_BITS-1:0] word;
            ans  = '{bit_is_set: 1'b0, found: 1'b0, found_index: '0, range_error: 1'b0};
            wc   = words_in_use();
            widx = offset / WORD_BITS;
            bpos = offset % WORD_BITS;
            if (cmd == CMD_CLEAR) begin
                clear_marks();
            end else if (offset >= wc * WORD_BITS) begin
                ans.range_error = 1'b1;
            end else begin
                case (cmd)
                    CMD_WRITE: begin
                        marks[widx][bpos] = value;
                    end
                    CMD_TEST: begin
                        ans.bit_is_set = marks[widx][bpos];
                    end
                    default: begin
                        for (w = widx; w < wc && !ans.found; w++) begin
                            word = marks[w];
                            // bits below the start position do not count in the first word
                            if (w == widx) word &= {WORD_BITS{1'b1}} << bpos;
                            for (b = 0; b < WORD_BITS && !ans.found; b++) begin
                                if (word[b]) begin
                                    ans.found       = 1'b1;
                                    ans.found_index = OFFSET_W'(w * WORD_BITS + b);
                                end
                            end
                        end
                    end
                endcase
            end
            pending_answers.push_back(ans);
        endfunction

        function void check_answer(t_answer got);
            t_answer want;
            if (pending_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result transaction with nothing outstanding", $realtime);
                return;
            end
            want = pending_answers.pop_front();
            if (got.bit_is_set !== want.bit_is_set || got.found !== want.found ||
                got.found_index !== want.found_index ||
                got.range_error !== want.range_error) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"%0t: mismatch expected set=%0b found=%0b index=%0d rerr=%0b,",
                              " got set=%0b found=%0b index=%0d rerr=%0b"},
                             $realtime, want.bit_is_set, want.found, want.found_index,
                             want.range_error, got.bit_is_set, got.found, got.found_index,
                             got.range_error);
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [WCOUNT_W-1:0]  i_cfg_wdata;

    bfns_in_if  in_if ();
    bfns_out_if out_if ();

    bitmap_tracker tracker = new();
    int unsigned   send_idle_pct;
    int unsigned   recv_idle_pct;
    int unsigned   cycles = 0;

    bitmap_find_next_set_unit #(
        .WORD_BITS (WORD_BITS),
        .WORDS     (WORDS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // result side: random backpressure plus one long hold-off
    initial begin
        int unsigned hold_left;
        int unsigned results_seen;
        t_answer     got;
        hold_left    = 0;
        results_seen = 0;
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready) begin
                got.bit_is_set  = out_if.bit_is_set;
                got.found       = out_if.found;
                got.found_index = out_if.found_index;
                got.range_error = out_if.range_error;
                tracker.check_answer(got);
                results_seen++;
                if (results_seen == HOLD_AT) hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                out_if.ready <= 1'b0;
                hold_left--;
            end else begin
                out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // called at a rising edge, returns at the edge where the transaction was taken
    task automatic send_command(t_cmd cmd, int unsigned offset, logic value);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.command    <= cmd;
        in_if.bit_offset <= offset[OFFSET_W-1:0];
        in_if.bit_value  <= value;
        in_if.valid      <= 1'b1;
        do @(posedge i_clk); while (!in_if.ready);
        tracker.note_command(cmd, offset[OFFSET_W-1:0], value);
    endtask

    // word count may only change with the block idle
    task automatic set_word_count(int unsigned value);
        in_if.valid <= 1'b0;
        while (tracker.pending_answers.size() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value[WCOUNT_W-1:0];
        @(posedge i_clk);
        tracker.set_word_count(value[WCOUNT_W-1:0]);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic run_directed();
        send_command(CMD_TEST,   0,     1'b0);
        send_command(CMD_SEARCH, 0,     1'b0);
        send_command(CMD_WRITE,  0,     1'b1);
        send_command(CMD_WRITE,  65535, 1'b1);
        send_command(CMD_TEST,   65535, 1'b0);
        send_command(CMD_SEARCH, 1,     1'b0);
        send_command(CMD_SEARCH, 0,     1'b0);
        send_command(CMD_WRITE,  63,    1'b1);
        send_command(CMD_WRITE,  64,    1'b1);
        send_command(CMD_SEARCH, 1,     1'b1);
        send_command(CMD_SEARCH, 64,    1'b0);
        send_command(CMD_SEARCH, 65,    1'b0);
        send_command(CMD_WRITE,  0,     1'b0);
        send_command(CMD_TEST,   0,     1'b1);
        // clear all ignores offset and value
        send_command(CMD_CLEAR,  65535, 1'b1);
        send_command(CMD_TEST,   65535, 1'b0);
        send_command(CMD_SEARCH, 0,     1'b0);
        set_word_count(1);
        send_command(CMD_WRITE,  63,    1'b1);
        send_command(CMD_WRITE,  64,    1'b1);
        send_command(CMD_TEST,   64,    1'b0);
        send_command(CMD_SEARCH, 64,    1'b0);
        send_command(CMD_SEARCH, 0,     1'b0);
        send_command(CMD_SEARCH, 63,    1'b0);
    endtask

    task automatic run_random(int unsigned items);
        int unsigned limit;
        int unsigned hot;
        int unsigned offset;
        int unsigned pick;
        int unsigned n;
        t_cmd        cmd;
        logic        value;
        limit = tracker.words_in_use() * WORD_BITS;
        hot   = 0;
        for (n = 0; n < items; n++) begin
            // writes and searches cluster around a moving spot so that searches hit
            if (n % 16 == 0) hot = $urandom_range(0, limit - 1);
            pick = $urandom_range(0, 99);
            if (pick < 3)       cmd = CMD_CLEAR;
            else if (pick < 42) cmd = CMD_WRITE;
            else if (pick < 65) cmd = CMD_TEST;
            else                cmd = CMD_SEARCH;
            value = ($urandom_range(0, 99) < 75);
            pick  = $urandom_range(0, 99);
            if (pick < 10) begin
                offset = $urandom_range(0, 65535);
            end else if (pick < 16) begin
                if (limit < 65536) offset = limit + $urandom_range(0, 63) % (65536 - limit);
                else offset = $urandom_range(0, 65535);
            end else if (pick < 22) begin
                offset = limit - 1 - $urandom_range(0, 3);
            end else begin
                offset = hot + $urandom_range(0, 191);
                if (offset >= limit) offset = limit - 1;
            end
            send_command(cmd, offset, value);
        end
    endtask

    initial begin
        int unsigned phase_wc [PHASES];
        int          p;
        phase_wc = '{2, 1024, 0, 5, 2047, 1, 3, 16, 1100};
        send_idle_pct     = 0;
        recv_idle_pct     = 0;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = '0;
        in_if.valid       = 1'b0;
        in_if.command     = CMD_WRITE;
        in_if.bit_offset  = '0;
        in_if.bit_value   = 1'b0;
        repeat (RESET_LEN) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        for (p = 0; p < PHASES; p++) begin
            if (p < 3) begin
                send_idle_pct = 10;
                recv_idle_pct = 87;
            end else if (p < 6) begin
                send_idle_pct = 87;
                recv_idle_pct = 10;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            set_word_count(phase_wc[p]);
            run_random(PHASE_ITEMS);
        end
        in_if.valid <= 1'b0;

        while (tracker.pending_answers.size() > 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.pending_answers.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
